>>> rtl/core/assert_macros.svh
// Assertion macros used by the sequencer of the rank search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check with no reset qualifier, for properties that also hold during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/drs_pkg.sv
// Package with the request and result types, codes and defaults of the rank search block.
`default_nettype none

package drs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SCORE_W         = 32;
    localparam int RANK_W          = 11;
    localparam int ACTION_W        = 2;
    localparam int STATUS_W        = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SCORE_W-1:0]  score;
    } req_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [STATUS_W-1:0] status;
    } res_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } drs_state_t;

endpackage

`default_nettype wire

>>> rtl/core/drs_table.sv
// Score table memory with one write port and one registered read port.
`default_nettype none

module drs_table #(
    parameter int DEPTH = drs_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [drs_pkg::SCORE_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [drs_pkg::SCORE_W-1:0] rd_data
);

    logic [drs_pkg::SCORE_W-1:0] mem [DEPTH];
    logic [drs_pkg::SCORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/drs_seq.sv
// Sequencer that handles loads and clears and runs the binary search over the table.
`default_nettype none
`include "assert_macros.svh"

module drs_seq #(
    parameter int DEPTH = drs_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire drs_pkg::req_t               request,
    output logic                             busy,
    output logic                             done,
    output drs_pkg::res_t                    result,
    output logic                             wr_en,
    output logic      [AW-1:0]               wr_addr,
    output logic      [drs_pkg::SCORE_W-1:0] wr_data,
    output logic                             rd_en,
    output logic      [AW-1:0]               rd_addr,
    input  wire logic [drs_pkg::SCORE_W-1:0] rd_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    drs_pkg::drs_state_t state_reg, state_next;

    logic [CW-1:0]               lo_reg, hi_reg, mid_reg, count_reg;
    logic [CW-1:0]               lo_next, hi_next, mid_next;
    logic [drs_pkg::SCORE_W-1:0] score_reg, last_reg;
    logic                        done_reg;
    drs_pkg::res_t               result_reg, result_next;

    logic                        accept;
    logic                        go_on;
    logic                        store_ok;
    logic                        done_next;
    logic [drs_pkg::STATUS_W-1:0] load_status;
    logic [CW:0]                 rank_w;

    assign accept = start && (state_reg == drs_pkg::S_IDLE);

    // One probe per cycle: the word read last cycle narrows the window and the
    // next midpoint is sent straight to the read port.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (state_reg == drs_pkg::S_SEARCH)
        begin
            if (rd_data > score_reg)
            begin
                lo_next = mid_reg + 1'b1;
            end
            else
            begin
                hi_next = mid_reg;
            end
        end
        else
        begin
            lo_next = '0;
            hi_next = count_reg;
        end
        mid_next = lo_next + ((hi_next - lo_next) >> 1);
        go_on    = (lo_next < hi_next);
        rank_w   = {1'b0, lo_next} + 1'b1;
    end

    // Load outcome: order tests against the last stored score come before the full test.
    always_comb
    begin
        store_ok    = 1'b0;
        load_status = drs_pkg::STAT_OK;
        if (count_reg == '0)
        begin
            store_ok = 1'b1;
        end
        else if (request.score == last_reg)
        begin
            load_status = drs_pkg::STAT_DUP;
        end
        else if (request.score > last_reg)
        begin
            load_status = drs_pkg::STAT_ORDER;
        end
        else if (count_reg >= DEPTH_C)
        begin
            load_status = drs_pkg::STAT_FULL;
        end
        else
        begin
            store_ok = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drs_pkg::S_IDLE:
            begin
                if (accept && (request.action == drs_pkg::ACT_QUERY) && go_on)
                begin
                    state_next = drs_pkg::S_SEARCH;
                end
            end
            drs_pkg::S_SEARCH:
            begin
                if (!go_on)
                begin
                    state_next = drs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = drs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        done_next   = 1'b0;
        result_next = '0;
        unique case (state_reg)
            drs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.action)
                        drs_pkg::ACT_LOAD:
                        begin
                            wr_en              = store_ok;
                            done_next          = 1'b1;
                            result_next.status = load_status;
                        end
                        drs_pkg::ACT_QUERY:
                        begin
                            rd_en     = go_on;
                            done_next = !go_on;
                            result_next.rank = drs_pkg::RANK_W'(rank_w);
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            drs_pkg::S_SEARCH:
            begin
                rd_en     = go_on;
                done_next = !go_on;
                result_next.rank = drs_pkg::RANK_W'(rank_w);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign rd_addr = mid_next[AW-1:0];
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = request.score;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drs_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (accept && (request.action == drs_pkg::ACT_CLEAR))
            begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            score_reg <= request.score;
        end
        if (wr_en)
        begin
            last_reg <= request.score;
        end
        if (rd_en)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
        end
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != drs_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_CLK(a_count_bound, count_reg <= DEPTH_C, "entry count above table depth")
    `ASSERT_CLK(a_window_open, (state_reg == drs_pkg::S_SEARCH) |-> (lo_reg < hi_reg),
        "search running on an empty window")
    `ASSERT_CLK(a_search_ends_in_result,
        ((state_reg == drs_pkg::S_SEARCH) && !go_on) |=> (done && (state_reg == drs_pkg::S_IDLE)),
        "finished search gave no result")
    `ASSERT_CLK(a_write_only_on_load,
        wr_en |-> (accept && (request.action == drs_pkg::ACT_LOAD)),
        "table written outside a load request")

endmodule

`default_nettype wire

>>> rtl/core/dense_rank_search_unit.sv
// Top level of the dense rank search block: sequencer plus score table memory.
`default_nettype none

// A request is taken when start is high and busy is low. Load, clear and unused
// actions leave busy low, and the result strobes on done in the next cycle. A query
// runs a binary search with one probe per cycle through the table's single registered
// read port, so busy stays high while the search runs; done is registered and strobes
// once the last probe's word has come back through the read register. A query on an
// empty table answers like a load, with no probe. Each result is shown on result for
// exactly one cycle with done high and must be taken then; there is no back-pressure.
// The table needs no clearing after reset: only entries below the count are read.
module dense_rank_search_unit #(
    parameter int TABLE_DEPTH = drs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire drs_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output drs_pkg::res_t      result
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [drs_pkg::SCORE_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [drs_pkg::SCORE_W-1:0] rd_data;

    drs_seq #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    drs_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the dense rank search unit: loads, queries and clears.
`timescale 1ns / 1ps

module tb;
    import drs_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int IDLE_LIMIT = 500;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Scoreboard: keeps its own copy of the score table and predicts every answer.
    class rank_tracker;
        logic [SCORE_W-1:0] scores[DEPTH];
        int unsigned fill;
        res_t pending[$];
        int errors;
        int action_seen[4];
        int status_seen[4];
        int unsigned max_rank;
        int unsigned max_fill;

        function void take_request(req_t r);
            res_t want;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            want = '0;
            case (r.action)
                ACT_LOAD:
                begin
                    if (fill == 0)
                    begin
                        scores[0] = r.score;
                        fill = 1;
                    end
                    else if (r.score == scores[fill-1])
                        want.status = STAT_DUP;
                    else if (r.score > scores[fill-1])
                        want.status = STAT_ORDER;
                    else if (fill >= DEPTH)
                        want.status = STAT_FULL;
                    else
                    begin
                        scores[fill] = r.score;
                        fill++;
                    end
                end
                ACT_QUERY:
                begin
                    // The table is strictly decreasing, so search for the first entry
                    // that is not above the score.
                    lo = 0;
                    hi = fill;
                    while (lo < hi)
                    begin
                        mid = (lo + hi) / 2;
                        if (scores[mid] > r.score)
                            lo = mid + 1;
                        else
                            hi = mid;
                    end
                    want.rank = RANK_W'(lo + 1);
                end
                ACT_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            action_seen[r.action]++;
            status_seen[want.status]++;
            if (want.rank > max_rank)
                max_rank = want.rank;
            if (fill > max_fill)
                max_fill = fill;
            pending.push_back(want);
        endfunction

        function void check_answer(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result with no request waiting: rank %0d status %0d",
                         $time, got.rank, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.rank !== want.rank)
            begin
                $display("%0t: rank mismatch: expected %0d, actual %0d",
                         $time, want.rank, got.rank);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    res_t result;

    rank_tracker tracker = new;
    logic [SCORE_W-1:0] loaded_scores[$];
    int burst_left = 0;
    int idle_cycles = 0;

    dense_rank_search_unit #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Results are checked before the request taken at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_answer(result);
            if (start && !busy)
                tracker.take_request(request);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Presents one request after a random gap and returns once it is taken and busy is low.
    task automatic send(input logic [ACTION_W-1:0] act, input logic [SCORE_W-1:0] s);
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 39) == 0)
            burst_left = $urandom_range(10, 30);
        else
            gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request <= '{action: act, score: s};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic clear_table();
        loaded_scores.delete();
        send(ACT_CLEAR, $urandom);
    endtask

    // An in-order load with widely varying steps, or a clear once the last score is 0.
    task automatic ordered_load();
        logic [SCORE_W-1:0] s;
        logic [SCORE_W-1:0] step;
        if (loaded_scores.size() == 0)
            s = $urandom;
        else if (loaded_scores[$] == 0)
        begin
            clear_table();
            return;
        end
        else
        begin
            step = $urandom_range(1, 1 << $urandom_range(0, 24));
            if (step > loaded_scores[$])
                step = loaded_scores[$];
            s = loaded_scores[$] - step;
        end
        if (loaded_scores.size() < DEPTH)
            loaded_scores.push_back(s);
        send(ACT_LOAD, s);
    endtask

    // A refused load (a repeat of the last score or higher), or an ordered one if empty.
    task automatic refused_load();
        logic [SCORE_W-1:0] tail;
        if (loaded_scores.size() == 0)
        begin
            ordered_load();
            return;
        end
        tail = loaded_scores[$];
        if (tail == '1 || $urandom_range(0, 1) == 0)
            send(ACT_LOAD, tail);
        else
            send(ACT_LOAD, tail + $urandom_range(1, ('1 - tail) > 1000 ? 1000 : ('1 - tail)));
    endtask

    function automatic logic [SCORE_W-1:0] query_score();
        int unsigned idx;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return '0;
            2: return '1;
            default:
            begin
                if (loaded_scores.size() == 0)
                    return $urandom;
                idx = $urandom_range(0, loaded_scores.size() - 1);
                return loaded_scores[idx] + $urandom_range(0, 2) - 1;
            end
        endcase
    endfunction

    task automatic mixed_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            ordered_load();
        else if (pick < 80)
            send(ACT_QUERY, query_score());
        else if (pick < 92)
            refused_load();
        else if (pick < 95)
            send(ACT_UNUSED, $urandom);
        else
            clear_table();
    endtask

    initial
    begin
        logic [SCORE_W-1:0] s;
        int pick;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, field extremes, duplicates, order violations,
        // the unused action and a query after clear.
        send(ACT_QUERY, 32'h0000_0000);
        send(ACT_QUERY, 32'hFFFF_FFFF);
        send(ACT_LOAD, 32'hFFFF_FFFF);
        send(ACT_LOAD, 32'hFFFF_FFFF);
        send(ACT_LOAD, 32'h8000_0000);
        send(ACT_LOAD, 32'h8000_0001);
        send(ACT_LOAD, 32'h0000_0000);
        send(ACT_LOAD, 32'h0000_0000);
        send(ACT_LOAD, 32'h0000_0005);
        send(ACT_QUERY, 32'hFFFF_FFFF);
        send(ACT_QUERY, 32'h8000_0000);
        send(ACT_QUERY, 32'h7FFF_FFFF);
        send(ACT_QUERY, 32'h0000_0000);
        send(ACT_UNUSED, 32'hAAAA_AAAA);
        send(ACT_UNUSED, 32'h5555_5555);
        send(ACT_CLEAR, 32'h0000_0000);
        send(ACT_QUERY, 32'h1234_5678);
        send(ACT_LOAD, 32'h0000_0000);
        send(ACT_QUERY, 32'h0000_0000);
        send(ACT_QUERY, 32'hFFFF_FFFF);
        send(ACT_CLEAR, 32'hFFFF_FFFF);
        loaded_scores.delete();

        repeat (250) mixed_request();

        // Fill the table to the last entry, with queries and refused loads mixed in.
        // The first entry always starts near the top so the descent cannot wrap.
        clear_table();
        while (loaded_scores.size() < DEPTH)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85 || loaded_scores.size() == 0)
            begin
                if (loaded_scores.size() == 0)
                    s = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                else
                    s = loaded_scores[$] - $urandom_range(1, 4_000_000);
                loaded_scores.push_back(s);
                send(ACT_LOAD, s);
            end
            else if (pick < 95)
                send(ACT_QUERY, query_score());
            else
                refused_load();
        end

        // Full table: drops, duplicates, order violations and the deepest ranks.
        repeat (60)
        begin
            case ($urandom_range(0, 3))
                0: send(ACT_LOAD, loaded_scores[$] - $urandom_range(1, 1000));
                1: send(ACT_LOAD, loaded_scores[$]);
                2: send(ACT_LOAD, loaded_scores[$] + $urandom_range(1, 1000));
                default: send(ACT_QUERY, $urandom_range(0, 1) ? 32'h0 : query_score());
            endcase
        end

        clear_table();
        repeat (200) mixed_request();

        start <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Requests: %0d load, %0d query, %0d clear, %0d unused action.",
                 tracker.action_seen[ACT_LOAD], tracker.action_seen[ACT_QUERY],
                 tracker.action_seen[ACT_CLEAR], tracker.action_seen[ACT_UNUSED]);
        $display("Status ok/dup/full/order: %0d/%0d/%0d/%0d; deepest table %0d, top rank %0d.",
                 tracker.status_seen[STAT_OK], tracker.status_seen[STAT_DUP],
                 tracker.status_seen[STAT_FULL], tracker.status_seen[STAT_ORDER],
                 tracker.max_fill, tracker.max_rank);
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/drs_pkg.sv
rtl/core/drs_table.sv
rtl/core/drs_seq.sv
rtl/core/dense_rank_search_unit.sv
bench/tb.sv
